// ===== rtl/core/lz10_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz10_pkg
// Shared types and constants of the LZ type-10 stream decompressor.
// ----------------------------------------------------------------------------
package lz10_pkg;

  localparam int unsigned HistDepth = 4096;
  localparam int unsigned HistAw    = $clog2(HistDepth);
  localparam int unsigned LenW      = 24;
  localparam int unsigned CntW      = 5;

  localparam logic [7:0] HeaderCodeRst = 8'h10;
  localparam logic [2:0] MinMatchLen   = 3'd3;
  localparam logic [3:0] FlagsPerGroup = 4'd8;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusMismatch = 2'd1;
  localparam logic [1:0] StatusEarlyEnd = 2'd2;

  typedef enum logic [4:0] {
    PH_TYPE   = 5'b00001,
    PH_LEN    = 5'b00010,
    PH_BODY   = 5'b00100,
    PH_MATCH2 = 5'b01000,
    PH_DRAIN  = 5'b10000
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_READ   = 4'b0100,
    S_COPY   = 4'b1000
  } state_e;

endpackage

// ===== rtl/core/lz10_stream_decompressor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz10_stream_decompressor_unit
// LZ77 type-10 (LZSS) decompressor with a 4 KiB history buffer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries the compressed stream one byte per word, with
//   tlast on the final byte. The master stream gives one word per output
//   byte; tuser marks data words and carries the status. tlast marks the
//   final word of a stream, which carries status (mismatch, early end, ok).
//   A header with the wrong type byte, a zero length or a completed stream
//   drops the remaining input words up to the one with tlast.
//   A header, flag or literal byte is taken in S_IDLE and decoded in
//   S_DECODE. After the second byte of a match is decoded, every copied
//   byte reads the single history port in S_READ, then is written back and
//   sent in S_COPY. A literal or status word enters the output register
//   from S_DECODE, the first copied byte of a match from S_COPY. The slave
//   side is not ready while a word is decoded or a match copied. A stalled
//   master stops the unit: one output word is held in a register, and
//   S_DECODE and S_COPY wait while it is full and not taken.
//   Reset clears all control state and sets header_code to 0x10. The
//   history needs no clearing pass: a fill count per stream makes entries
//   not yet written read as zero.
//   header_code may only be written while the unit is idle.
// ----------------------------------------------------------------------------
module lz10_stream_decompressor_unit
  import lz10_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,     // header_code
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
  input  logic       s_axis_tlast,    // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_byte
  output logic [2:0] m_axis_tuser,    // [0] has_data, [2:1] status
  output logic       m_axis_tlast     // out_last
);

  logic [7:0] header_code_q;
  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [1:0] hidx_q, hidx_d;
  logic [7:0] flags_q, flags_d;
  logic [3:0] fleft_q, fleft_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [7:0] mhigh_q, mhigh_d;
  logic [HistAw-1:0] wp_q, wp_d;
  logic full_q, full_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [HistAw-1:0] dist_q, dist_d;
  logic [7:0] byte_q;
  logic last_q;

  logic [7:0] mem_q [HistDepth];
  logic [7:0] rdata_q;
  logic rd_ok_q;
  logic rd_en;
  logic [HistAw-1:0] rd_addr;
  logic mem_we;
  logic [7:0] mem_wdata;

  logic out_valid_q;
  logic [7:0] out_byte_q;
  logic out_has_q;
  logic out_last_q;
  logic [1:0] out_status_q;

  logic emit;
  logic [7:0] emit_byte;
  logic emit_has;
  logic emit_last;
  logic [1:0] emit_status;

  logic slot_free;
  logic [LenW-1:0] rem_dec;
  logic done;
  logic [LenW-1:0] len_byte;
  logic [CntW-1:0] match_len;
  logic [7:0] copy_data;

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign rem_dec       = rem_q - 1'b1;
  assign done          = (rem_dec == '0);
  assign match_len     = CntW'(mhigh_q[7:4]) + CntW'(MinMatchLen);
  assign rd_addr       = wp_q - dist_q - 1'b1;
  assign copy_data     = rd_ok_q ? rdata_q : 8'h00;

  always_comb begin
    case (hidx_q)
      2'd0:    len_byte = {16'h0000, byte_q};
      2'd1:    len_byte = {8'h00, byte_q, 8'h00};
      2'd2:    len_byte = {byte_q, 16'h0000};
      default: len_byte = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    hidx_d      = hidx_q;
    flags_d     = flags_q;
    fleft_d     = fleft_q;
    rem_d       = rem_q;
    mhigh_d     = mhigh_q;
    wp_d        = wp_q;
    full_d      = full_q;
    cnt_d       = cnt_q;
    dist_d      = dist_q;
    emit        = 1'b0;
    emit_byte   = 8'h00;
    emit_has    = 1'b0;
    emit_last   = 1'b0;
    emit_status = StatusOk;
    mem_we      = 1'b0;
    mem_wdata   = byte_q;
    rd_en       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (slot_free) begin
          state_d = S_IDLE;
          case (phase_q)
            PH_TYPE: begin
              hidx_d  = '0;
              flags_d = '0;
              fleft_d = '0;
              rem_d   = '0;
              mhigh_d = '0;
              wp_d    = '0;
              full_d  = 1'b0;
              if (byte_q != header_code_q) begin
                emit        = 1'b1;
                emit_last   = 1'b1;
                emit_status = StatusMismatch;
                phase_d     = last_q ? PH_TYPE : PH_DRAIN;
              end else if (last_q) begin
                emit        = 1'b1;
                emit_last   = 1'b1;
                emit_status = StatusEarlyEnd;
                phase_d     = PH_TYPE;
              end else begin
                phase_d = PH_LEN;
              end
            end
            PH_LEN: begin
              rem_d  = rem_q | len_byte;
              hidx_d = hidx_q + 1'b1;
              if (hidx_q == 2'd2 && rem_d == '0) begin
                emit      = 1'b1;
                emit_last = 1'b1;
                phase_d   = last_q ? PH_TYPE : PH_DRAIN;
              end else if (last_q) begin
                emit        = 1'b1;
                emit_last   = 1'b1;
                emit_status = StatusEarlyEnd;
                phase_d     = PH_TYPE;
              end else if (hidx_q == 2'd2) begin
                phase_d = PH_BODY;
              end
            end
            PH_BODY: begin
              if (fleft_q != '0 && !flags_q[7]) begin
                flags_d     = {flags_q[6:0], 1'b0};
                fleft_d     = fleft_q - 1'b1;
                mem_we      = 1'b1;
                wp_d        = wp_q + 1'b1;
                full_d      = full_q | (wp_q == '1);
                rem_d       = rem_dec;
                emit        = 1'b1;
                emit_byte   = byte_q;
                emit_has    = 1'b1;
                emit_last   = done || last_q;
                emit_status = (!done && last_q) ? StatusEarlyEnd : StatusOk;
                if (done) begin
                  phase_d = last_q ? PH_TYPE : PH_DRAIN;
                end else if (last_q) begin
                  phase_d = PH_TYPE;
                end
              end else begin
                if (fleft_q == '0) begin
                  flags_d = byte_q;
                  fleft_d = FlagsPerGroup;
                end else begin
                  flags_d = {flags_q[6:0], 1'b0};
                  fleft_d = fleft_q - 1'b1;
                  mhigh_d = byte_q;
                  phase_d = PH_MATCH2;
                end
                if (last_q) begin
                  emit        = 1'b1;
                  emit_last   = 1'b1;
                  emit_status = StatusEarlyEnd;
                  phase_d     = PH_TYPE;
                end
              end
            end
            PH_MATCH2: begin
              cnt_d   = (rem_q < LenW'(match_len)) ? rem_q[CntW-1:0] : match_len;
              dist_d  = {mhigh_q[3:0], byte_q};
              phase_d = PH_BODY;
              state_d = S_READ;
            end
            default: begin
              if (last_q) begin
                phase_d = PH_TYPE;
              end
            end
          endcase
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_COPY;
      end
      S_COPY: begin
        if (slot_free) begin
          mem_we    = 1'b1;
          mem_wdata = copy_data;
          wp_d      = wp_q + 1'b1;
          full_d    = full_q | (wp_q == '1);
          rem_d     = rem_dec;
          cnt_d     = cnt_q - 1'b1;
          emit      = 1'b1;
          emit_byte = copy_data;
          emit_has  = 1'b1;
          if (cnt_q == CntW'(1)) begin
            emit_last   = done || last_q;
            emit_status = (!done && last_q) ? StatusEarlyEnd : StatusOk;
            state_d     = S_IDLE;
            if (done) begin
              phase_d = last_q ? PH_TYPE : PH_DRAIN;
            end else if (last_q) begin
              phase_d = PH_TYPE;
            end
          end else begin
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_code_q <= HeaderCodeRst;
      state_q       <= S_IDLE;
      phase_q       <= PH_TYPE;
      hidx_q        <= '0;
      flags_q       <= '0;
      fleft_q       <= '0;
      rem_q         <= '0;
      mhigh_q       <= '0;
      wp_q          <= '0;
      full_q        <= 1'b0;
      cnt_q         <= '0;
      dist_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        header_code_q <= cfg_wdata_i;
      end
      state_q <= state_d;
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      flags_q <= flags_d;
      fleft_q <= fleft_d;
      rem_q   <= rem_d;
      mhigh_q <= mhigh_d;
      wp_q    <= wp_d;
      full_q  <= full_d;
      cnt_q   <= cnt_d;
      dist_q  <= dist_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    if (emit) begin
      out_byte_q   <= emit_byte;
      out_has_q    <= emit_has;
      out_last_q   <= emit_last;
      out_status_q <= emit_status;
    end
    if (rd_en) begin
      rd_ok_q <= full_q || (rd_addr < wp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = {out_status_q, out_has_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lz10_stream_decompressor_unit. Compressed streams
// go in one byte per word: a short directed set (literals, overlapping match,
// type mismatch, zero length, maximum length cut short by tlast), then random
// streams under four header_code settings. Most random streams are well
// formed. The rest are cut short, mismatched, zero length or padded with
// trailing bytes. A software decoder predicts every output word, and the
// monitor compares each one field by field. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;
  import lz10_pkg::*;

  localparam int CycleLimit  = 2_000_000;
  localparam int DrainCycles = 64;
  localparam int PhaseWords  = 96;
  localparam int MaxBody     = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [7:0] cfg_wdata_i   = 8'h00;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  lz10_stream_decompressor_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // decoder state
  logic [7:0]      hdr_code = HeaderCodeRst;
  phase_e          dec_phase = PH_TYPE;
  logic [1:0]      hdr_idx;
  logic [7:0]      flag_sr;
  logic [3:0]      flags_left;
  logic [LenW-1:0] remaining;
  logic [7:0]      match_hi;
  logic [11:0]     wr_ptr;
  logic [7:0]      hist_mem [HistDepth];

  out_word_t exp_q[$];
  in_word_t  pend_q[$];
  int        words_sent = 0;
  int        words_acc  = 0;
  int        err_cnt    = 0;
  int        cyc        = 0;

  task automatic push_result(input logic [7:0] d, input logic h, input logic l,
                             input logic [1:0] st);
    out_word_t w;
    w.data = d;
    w.has_data = h;
    w.last = l;
    w.status = st;
    exp_q.push_back(w);
  endtask

  task automatic emit_byte(input logic [7:0] b);
    hist_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 12'd1;
    remaining = remaining - 1'b1;
    push_result(b, 1'b1, 1'b0, StatusOk);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic lst);
    int          base;
    int          len;
    logic [15:0] pair;
    logic [11:0] src;
    out_word_t   tail;
    base = exp_q.size();
    case (dec_phase)
      PH_TYPE: begin
        hdr_idx = '0;
        flag_sr = '0;
        flags_left = '0;
        remaining = '0;
        match_hi = '0;
        wr_ptr = '0;
        for (int i = 0; i < HistDepth; i++) hist_mem[i] = 8'h00;
        if (b != hdr_code) begin
          push_result(8'h00, 1'b0, 1'b1, StatusMismatch);
          dec_phase = lst ? PH_TYPE : PH_DRAIN;
          return;
        end
        dec_phase = PH_LEN;
      end
      PH_LEN: begin
        remaining = remaining | (LenW'(b) << (8 * hdr_idx));
        hdr_idx = hdr_idx + 2'd1;
        if (hdr_idx == 2'd3) begin
          dec_phase = PH_BODY;
          if (remaining == '0) begin
            push_result(8'h00, 1'b0, 1'b1, StatusOk);
            dec_phase = lst ? PH_TYPE : PH_DRAIN;
            return;
          end
        end
      end
      PH_BODY: begin
        if (flags_left == 4'd0) begin
          flag_sr = b;
          flags_left = FlagsPerGroup;
        end else begin
          flags_left = flags_left - 4'd1;
          if (flag_sr[7]) begin
            match_hi = b;
            dec_phase = PH_MATCH2;
          end else begin
            emit_byte(b);
          end
          flag_sr = flag_sr << 1;
        end
      end
      PH_MATCH2: begin
        pair = {match_hi, b};
        len = int'(pair[15:12]) + 3;
        if (len > remaining) len = int'(remaining);
        for (int i = 0; i < len; i++) begin
          src = wr_ptr - pair[11:0] - 12'd1;
          emit_byte(hist_mem[src]);
        end
        dec_phase = PH_BODY;
      end
      default: begin
        if (lst) dec_phase = PH_TYPE;
        return;
      end
    endcase

    if ((dec_phase == PH_BODY || dec_phase == PH_MATCH2) && remaining == '0) begin
      if (exp_q.size() > base) begin
        tail = exp_q.pop_back();
        tail.last = 1'b1;
        exp_q.push_back(tail);
      end
      dec_phase = lst ? PH_TYPE : PH_DRAIN;
      return;
    end
    if (lst) begin
      if (exp_q.size() > base) begin
        tail = exp_q.pop_back();
        tail.last = 1'b1;
        tail.status = StatusEarlyEnd;
        exp_q.push_back(tail);
      end else begin
        push_result(8'h00, 1'b0, 1'b1, StatusEarlyEnd);
      end
      dec_phase = PH_TYPE;
    end
  endtask

  // sender: bursts with random gaps
  in_word_t nxt_w;
  int       burst_left = 0;
  int       gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
        words_acc++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          nxt_w = pend_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt_w.data;
          s_axis_tlast  <= nxt_w.last;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 60);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = $urandom_range(0, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between modes, and output check
  int        rx_mode = 0;
  int        rx_left = 0;
  logic      rx_rdy;
  out_word_t got_w;
  out_word_t exp_w;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_w = {m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[2:1]};
        if (exp_q.size() == 0) begin
          $error("unexpected word: out_byte %0h has_data %0b out_last %0b status %0d",
                 got_w.data, got_w.has_data, got_w.last, got_w.status);
          err_cnt++;
        end else begin
          exp_w = exp_q.pop_front();
          if (got_w.data != exp_w.data) begin
            $error("out_byte: expected %0h, got %0h", exp_w.data, got_w.data);
            err_cnt++;
          end
          if (got_w.has_data != exp_w.has_data) begin
            $error("has_data: expected %0b, got %0b", exp_w.has_data, got_w.has_data);
            err_cnt++;
          end
          if (got_w.last != exp_w.last) begin
            $error("out_last: expected %0b, got %0b", exp_w.last, got_w.last);
            err_cnt++;
          end
          if (got_w.status != exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, got_w.status);
            err_cnt++;
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 160);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: rx_rdy = 1'b1;
        1: rx_rdy = ($urandom_range(0, 3) != 0);
        2: rx_rdy = ($urandom_range(0, 3) == 0);
        default: rx_rdy = ((cyc % 8) < 4);
      endcase
      m_axis_tready <= rx_rdy;
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] d, input logic l);
    in_word_t w;
    w.data = d;
    w.last = l;
    pend_q.push_back(w);
    words_sent++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (words_acc != words_sent || exp_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_code(input logic [7:0] v);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    hdr_code = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic gen_stream(output int useful);
    logic [7:0]  body[$];
    logic [7:0]  flags;
    logic [7:0]  t;
    logic [3:0]  nib;
    logic [11:0] dfield;
    int          kind;
    int          len_decl;
    int          target;
    int          produced;
    int          span;
    int          cut;
    int          pad;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      do t = 8'($urandom); while (t == hdr_code);
      pad = $urandom_range(0, 3);
      push_word(t, pad == 0);
      for (int i = 1; i <= pad; i++) push_word(8'($urandom), i == pad);
      useful = 1;
      return;
    end
    if (kind < 16) len_decl = 0;
    else if (kind < 28) len_decl = $urandom_range(0, 24'hFFFFFF);
    else if (kind < 33) len_decl = $urandom_range(150, 400);
    else if (kind < 55) len_decl = $urandom_range(25, 80);
    else len_decl = $urandom_range(1, 24);
    target = (len_decl > MaxBody && kind < 28) ? MaxBody : len_decl;

    body.push_back(hdr_code);
    body.push_back(len_decl[7:0]);
    body.push_back(len_decl[15:8]);
    body.push_back(len_decl[23:16]);
    produced = 0;
    while (produced < target) begin
      flags = 8'($urandom);
      body.push_back(flags);
      for (int b = 7; b >= 0 && produced < target; b--) begin
        if (flags[b]) begin
          nib = 4'($urandom);
          if (produced > 0 && $urandom_range(0, 4) != 0)
            dfield = 12'($urandom_range(1, produced > HistDepth ? HistDepth : produced) - 1);
          else
            dfield = 12'($urandom);
          body.push_back({nib, dfield[11:8]});
          body.push_back(dfield[7:0]);
          span = int'(nib) + 3;
          produced += (span > len_decl - produced) ? len_decl - produced : span;
        end else begin
          body.push_back(8'($urandom));
          produced++;
        end
      end
    end

    pad = 0;
    if (produced < len_decl) begin
      cut = ($urandom_range(0, 9) < 3) ? $urandom_range(0, body.size() - 1) : body.size() - 1;
    end else if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(0, body.size() - 2);
    end else begin
      cut = body.size() - 1;
      pad = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    end
    for (int i = 0; i <= cut; i++) push_word(body[i], i == cut && pad == 0);
    for (int i = 1; i <= pad; i++) push_word(8'($urandom), i == pad);
    useful = cut + 1;
  endtask

  task automatic gen_phase();
    int n;
    int u;
    n = 0;
    while (n < PhaseWords) begin
      gen_stream(u);
      n += u;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // literal, overlapping match, literal closing the stream
    push_word(HeaderCodeRst, 1'b0);
    push_word(8'h05, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h40, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b1);
    // type mismatch with trailing words, then on a lone tlast word
    push_word(8'hAB, 1'b0);
    push_word(8'h01, 1'b0);
    push_word(8'h02, 1'b1);
    push_word(8'h00, 1'b1);
    // zero length, trailing word dropped
    push_word(HeaderCodeRst, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h55, 1'b1);
    // maximum length, longest match reaching before start, early end
    push_word(HeaderCodeRst, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b1);

    set_code(8'h00);
    gen_phase();
    set_code(8'hFF);
    gen_phase();
    set_code(8'($urandom_range(1, 254)));
    gen_phase();
    set_code(HeaderCodeRst);
    gen_phase();

    wait_drained();
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lz10_pkg.sv
rtl/core/lz10_stream_decompressor_unit.sv
tb/sv/tb.sv
